// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define HCBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define HCBD_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define HCBD_ASSERT(label, clk, rst, prop, msg)
`define HCBD_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ----- rtl/core/hcbd_pkg.sv -----
// shared types and constants of the chunked body decoder
package hcbd_pkg;

   localparam int COUNT_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   typedef struct packed {
      logic       has_data;
      logic [7:0] data;
      logic       has_end;
   } hcbd_entry_type;

endpackage

// ----- rtl/core/hcbd_front.sv -----
// front end: size line parser and chunk byte counter
`include "assert_macros.svh"

module hcbd_front
   import hcbd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_body_byte,
   input  logic           req_body_end,
   input  logic           q_full,
   output logic           push_valid,
   output hcbd_entry_type push_entry
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_REST,
      PH_DATA,
      PH_TRAIL1,
      PH_TRAIL2,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] size_accum_ff, size_accum_in;
   logic [COUNT_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                  accept;
   logic                  has_data;
   logic                  has_end;
   logic                  ended;
   logic [4:0]            hex;
   logic [COUNT_BITS-1:0] accum_digit;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, 4'(c - CHAR_ZERO)};
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
      end
      return r;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign hex       = hex_digit(req_body_byte);

   // saturate once the top nibble is in use
   assign accum_digit = (|size_accum_ff[COUNT_BITS-1:COUNT_BITS-4]) ?
                        {COUNT_BITS{1'b1}} :
                        {size_accum_ff[COUNT_BITS-5:0], hex[3:0]};

   always_comb begin
      phase_in      = phase_ff;
      size_accum_in = size_accum_ff;
      bytes_left_in = bytes_left_ff;
      has_data      = 1'b0;
      ended         = 1'b0;
      unique case (phase_ff)
         PH_LEAD, PH_DIGITS, PH_REST: begin
            if (req_body_byte == CHAR_LF) begin
               // end of size line
               if (size_accum_ff == '0) begin
                  ended = 1'b1;
               end else begin
                  bytes_left_in = size_accum_ff;
                  size_accum_in = '0;
                  phase_in      = PH_DATA;
               end
            end else if (phase_ff == PH_LEAD && (req_body_byte == CHAR_SPACE ||
                         req_body_byte == CHAR_TAB || req_body_byte == CHAR_PLUS)) begin
               phase_in = PH_LEAD;
            end else if (phase_ff != PH_REST && hex[4]) begin
               size_accum_in = accum_digit;
               phase_in      = PH_DIGITS;
            end else begin
               phase_in = PH_REST;
            end
         end
         PH_DATA: begin
            has_data      = 1'b1;
            bytes_left_in = bytes_left_ff - COUNT_BITS'(1);
            if (bytes_left_ff == COUNT_BITS'(1)) begin
               phase_in = PH_TRAIL1;
            end
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            phase_in      = PH_LEAD;
            size_accum_in = '0;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      has_end = (phase_ff != PH_DONE) && (ended || req_body_end);
      if (has_end) begin
         phase_in = PH_DONE;
      end
   end

   assign push_valid          = accept && (has_data || has_end);
   assign push_entry.has_data = has_data;
   assign push_entry.data     = req_body_byte;
   assign push_entry.has_end  = has_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         size_accum_ff <= '0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         size_accum_ff <= size_accum_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   `HCBD_ASSERT(a_done_sticks, clock, reset, (phase_ff == PH_DONE) |=> (phase_ff == PH_DONE), "decoder left done phase")
   `HCBD_ASSERT(a_end_to_done, clock, reset, (push_valid && push_entry.has_end) |=> (phase_ff == PH_DONE), "end marker without done phase")

endmodule

// ----- rtl/core/hcbd_queue.sv -----
// short queue of decoded entries between front and back
`include "assert_macros.svh"

module hcbd_queue
   import hcbd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  hcbd_entry_type push_entry,
   output logic           q_full,
   input  logic           pop,
   output logic           q_valid,
   output hcbd_entry_type q_entry
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   hcbd_entry_type         slots_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic                   do_pop;

   assign q_full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = slots_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (!push_valid && do_pop) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

   `HCBD_NEVER(a_no_overflow, clock, reset, push_valid && q_full, "push into full queue")
   `HCBD_NEVER(a_count_range, clock, reset, count_ff > CNT_BITS'(DEPTH), "queue count out of range")

endmodule

// ----- rtl/core/hcbd_back.sv -----
// back end: expands queued entries into result transactions
`include "assert_macros.svh"

module hcbd_back
   import hcbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  hcbd_entry_type q_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_kind,
   output logic [7:0]     rsp_payload_byte
);

   logic       rsp_valid_ff;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_payload_byte_ff, rsp_payload_byte_in;
   logic       pend_end_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = out_free && !pend_end_ff && q_valid;

   always_comb begin
      if (!pend_end_ff && q_entry.has_data) begin
         rsp_kind_in         = KIND_DATA;
         rsp_payload_byte_in = q_entry.data;
      end else begin
         rsp_kind_in         = KIND_END;
         rsp_payload_byte_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_end_ff  <= 1'b0;
      end else if (out_free) begin
         if (pend_end_ff) begin
            rsp_valid_ff <= 1'b1;
            pend_end_ff  <= 1'b0;
         end else if (q_valid) begin
            rsp_valid_ff <= 1'b1;
            pend_end_ff  <= q_entry.has_data && q_entry.has_end;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && (pend_end_ff || q_valid)) begin
         rsp_kind_ff         <= rsp_kind_in;
         rsp_payload_byte_ff <= rsp_payload_byte_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;

   `HCBD_ASSERT(a_pend_after_data, clock, reset, pend_end_ff |-> (rsp_valid_ff && rsp_kind_ff == KIND_DATA), "pending end without data transaction")

endmodule

// ----- rtl/core/http_chunked_body_decoder.sv -----
// top level of the chunked transfer body decoder
// usage:
//   req_ channel takes one body byte per transaction, req_body_end flags the last one
//   rsp_ channel gives decoded payload bytes (rsp_kind 0) and one end marker (rsp_kind 1)
//   a transaction completes on a clock edge with valid high and stall low
// timing:
//   one input byte per cycle sustained while the queue is not full; a byte that yields a result
//   reaches rsp_ through the entry queue and then the output register
//   a byte that yields both a payload byte and the end marker holds the output for the
//   payload byte and then the end marker; the queue of QUEUE_DEPTH entries absorbs this
//   and short output stalls; req_stall rises only when the queue is full
// reset:
//   synchronous, clears parser state, the queue and the output valid flag; the decoder
//   then waits for the first size line
// after the end marker all further input bytes are accepted and dropped
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_body_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte
);

   logic           push_valid;
   hcbd_entry_type push_entry;
   logic           q_full;
   logic           q_valid;
   hcbd_entry_type q_entry;
   logic           pop;

   hcbd_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_body_byte (req_body_byte),
      .req_body_end  (req_body_end),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   hcbd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   hcbd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte)
   );

endmodule
